[design/infix_to_postfix_converter_assert.svh]
// Assertion macros shared by the converter modules.
// ITP_ASSERT checks a property at every rising clock edge outside reset.
// ITP_ASSERT_NEVER checks that an expression is never true.
`ifndef INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH

`ifndef SYNTHESIS
`define ITP_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("itp assertion failed");
`define ITP_ASSERT_NEVER(name, clk, rst_n, expr) \
  `ITP_ASSERT(name, clk, rst_n, !(expr))
`else
`define ITP_ASSERT(name, clk, rst_n, prop)
`define ITP_ASSERT_NEVER(name, clk, rst_n, expr)
`endif

`endif

[design/itp_pkg.sv]
package itp_pkg;

  localparam logic [7:0] ChMul   = 8'h2A;
  localparam logic [7:0] ChDiv   = 8'h2F;
  localparam logic [7:0] ChAdd   = 8'h2B;
  localparam logic [7:0] ChSub   = 8'h2D;
  localparam logic [7:0] ChPow   = 8'h5E;
  localparam logic [7:0] ChOpen  = 8'h28;
  localparam logic [7:0] ChClose = 8'h29;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5A;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerZ = 8'h7A;

  localparam logic [1:0] StatOk             = 2'd0;
  localparam logic [1:0] StatOverflow       = 2'd1;
  localparam logic [1:0] StatUnmatchedClose = 2'd2;
  localparam logic [1:0] StatUnmatchedOpen  = 2'd3;

  typedef enum logic [1:0] {
    ClsLetter,
    ClsOpen,
    ClsClose,
    ClsOper
  } char_class_e;

  typedef enum logic [2:0] {
    EmitNone,
    EmitChar,
    EmitTop,
    EmitPend,
    EmitFinal
  } emit_src_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       push;
    logic       pop;
    emit_src_e  emit;
    logic       pend_load;
    logic [1:0] flag;
    logic       clear_err;
  } itp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    char_class_e in_class;
    logic        in_finish;
    logic        empty;
    logic        top_open;
    logic        top_pops;
    logic        pend_valid;
    logic        out_free;
  } itp_status_t;

  function automatic logic [2:0] prec(input logic [7:0] c);
    logic [2:0] p;
    case (c)
      ChMul:   p = 3'd5;
      ChDiv:   p = 3'd4;
      ChAdd:   p = 3'd3;
      ChSub:   p = 3'd2;
      ChPow:   p = 3'd1;
      default: p = 3'd0;
    endcase
    return p;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= ChUpperA) && (c <= ChUpperZ)) || ((c >= ChLowerA) && (c <= ChLowerZ));
  endfunction

endpackage

[design/itp_in_if.sv]
interface itp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       finish;

  modport source (output valid, output character, output finish, input ready);
  modport sink (input valid, input character, input finish, output ready);
endinterface

[design/itp_out_if.sv]
interface itp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       symbol_valid;
  logic       last;
  logic [1:0] status;

  modport source (output valid, output symbol, output symbol_valid, output last,
                  output status, input ready);
  modport sink (input valid, input symbol, input symbol_valid, input last,
                input status, output ready);
endinterface

[design/itp_datapath.sv]
`include "infix_to_postfix_converter_assert.svh"

module itp_datapath #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          character_i,
  input  logic                finish_i,
  input  itp_pkg::itp_cmd_t   cmd_i,
  output itp_pkg::itp_status_t status_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [7:0]          symbol_o,
  output logic                symbol_valid_o,
  output logic                last_o,
  output logic [1:0]          out_status_o
);
  import itp_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  logic [7:0]    mem [STACK_DEPTH];
  logic [7:0]    rdata_q;
  logic [CW-1:0] count_q, count_d, count_m1;
  logic [AW-1:0] raddr, waddr;
  logic          we, full;
  logic [1:0]    err_q, err_d, flag_code;
  logic [7:0]    char_q;
  logic [7:0]    pend_q;
  logic          pend_valid_q;
  logic          out_valid_q;
  logic          out_free;
  logic [7:0]    sym_q;
  logic          sym_valid_q, last_q;
  logic [1:0]    stat_q;
  char_class_e   in_class;

  assign full     = (count_q == CW'(STACK_DEPTH));
  assign we       = cmd_i.push && !full;
  assign waddr    = count_q[AW-1:0];
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    count_d = count_q;
    if (we) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.pop) begin
      count_d = count_q - CW'(1);
    end
  end

  // The read port always fetches the entry that will be on top next cycle,
  // so rdata_q holds the top of stack whenever the stack is not empty.
  assign count_m1 = count_d - CW'(1);
  assign raddr    = count_m1[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= char_q;
    end
    if (we && (waddr == raddr)) begin
      rdata_q <= char_q;
    end else begin
      rdata_q <= mem[raddr];
    end
  end

  // The first error of an expression sticks until the final result.
  always_comb begin
    flag_code = cmd_i.flag;
    if (cmd_i.push && full) begin
      flag_code = StatOverflow;
    end
    err_d = err_q;
    if (err_q == StatOk) begin
      err_d = flag_code;
    end
    if (cmd_i.clear_err) begin
      err_d = StatOk;
    end
  end

  always_comb begin
    if (is_letter(character_i)) begin
      in_class = ClsLetter;
    end else if (character_i == ChOpen) begin
      in_class = ClsOpen;
    end else if (character_i == ChClose) begin
      in_class = ClsClose;
    end else begin
      in_class = ClsOper;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      err_q        <= StatOk;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      err_q   <= err_d;
      if (cmd_i.emit == EmitFinal) begin
        pend_valid_q <= 1'b0;
      end else if (cmd_i.pend_load) begin
        pend_valid_q <= 1'b1;
      end
      if (cmd_i.emit != EmitNone) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      char_q <= character_i;
    end
    if (cmd_i.pend_load) begin
      pend_q <= rdata_q;
    end
    case (cmd_i.emit)
      EmitChar: begin
        sym_q       <= char_q;
        sym_valid_q <= 1'b1;
        last_q      <= 1'b0;
        stat_q      <= StatOk;
      end
      EmitTop: begin
        sym_q       <= rdata_q;
        sym_valid_q <= 1'b1;
        last_q      <= 1'b0;
        stat_q      <= StatOk;
      end
      EmitPend: begin
        sym_q       <= pend_q;
        sym_valid_q <= 1'b1;
        last_q      <= 1'b0;
        stat_q      <= StatOk;
      end
      EmitFinal: begin
        sym_q       <= pend_valid_q ? pend_q : 8'h00;
        sym_valid_q <= pend_valid_q;
        last_q      <= 1'b1;
        stat_q      <= err_q;
      end
      default: begin
      end
    endcase
  end

  assign status_o.in_class   = in_class;
  assign status_o.in_finish  = finish_i;
  assign status_o.empty      = (count_q == '0);
  assign status_o.top_open   = (rdata_q == ChOpen);
  assign status_o.top_pops   = (prec(rdata_q) >= prec(char_q));
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.out_free   = out_free;

  assign out_valid_o    = out_valid_q;
  assign symbol_o       = sym_q;
  assign symbol_valid_o = sym_valid_q;
  assign last_o         = last_q;
  assign out_status_o   = stat_q;

  `ITP_ASSERT(a_count_range, clk_i, rst_ni, count_q <= CW'(STACK_DEPTH))
  `ITP_ASSERT(a_pop_nonempty, clk_i, rst_ni, cmd_i.pop |-> (count_q != '0))
  `ITP_ASSERT_NEVER(a_emit_busy, clk_i, rst_ni, (cmd_i.emit != EmitNone) && !out_free)
  `ITP_ASSERT(a_final_clears, clk_i, rst_ni, (cmd_i.emit == EmitFinal) |=> ((err_q == StatOk) && !pend_valid_q))

endmodule

[design/itp_controller.sv]
module itp_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  itp_pkg::itp_status_t status_i,
  output itp_pkg::itp_cmd_t    cmd_o
);
  import itp_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StLetter,
    StOpen,
    StClose,
    StOper,
    StFlush
  } state_e;

  state_e   state_q, state_d;
  logic     ready_q;
  itp_cmd_t cmd;

  always_comb begin
    cmd     = '0;
    cmd.emit = EmitNone;
    cmd.flag = StatOk;
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          if (status_i.in_finish) begin
            state_d = StFlush;
          end else begin
            case (status_i.in_class)
              ClsLetter: state_d = StLetter;
              ClsOpen:   state_d = StOpen;
              ClsClose:  state_d = StClose;
              default:   state_d = StOper;
            endcase
          end
        end
      end
      StLetter: begin
        if (status_i.out_free) begin
          cmd.emit = EmitChar;
          state_d  = StIdle;
        end
      end
      StOpen: begin
        cmd.push = 1'b1;
        state_d  = StIdle;
      end
      StOper: begin
        if (!status_i.empty && !status_i.top_open && status_i.top_pops) begin
          if (status_i.out_free) begin
            cmd.emit = EmitTop;
            cmd.pop  = 1'b1;
          end
        end else begin
          cmd.push = 1'b1;
          state_d  = StIdle;
        end
      end
      StClose: begin
        if (status_i.empty) begin
          cmd.flag = StatUnmatchedClose;
          state_d  = StIdle;
        end else if (status_i.top_open) begin
          cmd.pop = 1'b1;
          state_d = StIdle;
        end else if (status_i.out_free) begin
          cmd.emit = EmitTop;
          cmd.pop  = 1'b1;
        end
      end
      StFlush: begin
        // One symbol is held back so that the final one can carry last.
        if (!status_i.empty) begin
          if (status_i.top_open) begin
            cmd.pop  = 1'b1;
            cmd.flag = StatUnmatchedOpen;
          end else if (!status_i.pend_valid) begin
            cmd.pop       = 1'b1;
            cmd.pend_load = 1'b1;
          end else if (status_i.out_free) begin
            cmd.emit      = EmitPend;
            cmd.pop       = 1'b1;
            cmd.pend_load = 1'b1;
          end
        end else if (status_i.out_free) begin
          cmd.emit      = EmitFinal;
          cmd.clear_err = 1'b1;
          state_d       = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ready_q <= 1'b1;
    end else begin
      state_q <= state_d;
      ready_q <= (state_d == StIdle);
    end
  end

  assign in_ready_o = ready_q;
  assign cmd_o      = cmd;

endmodule

[design/infix_to_postfix_converter.sv]
// Infix-to-postfix converter with an operator stack of STACK_DEPTH entries.
// Input channel in_i carries one expression character per transfer; finish
// marks the end of an expression and ignores the character. Output channel
// out_o carries postfix symbols; the final result of a finish transfer has
// last set and the sticky status (overflow, unmatched close, unmatched open).
// One item is worked at a time, and in_i.ready is low while it is in work.
// The stack memory is read once per cycle, so while out_o can take results,
// one entry leaves the stack per cycle for an operator, close or finish that
// pops. A result appears on out_o in the cycle after the one that produces it.
// Results sit in a single output register; while it holds a result that
// out_o.ready does not take, the block holds in the state that wants to emit
// and accepts nothing new. Reset empties the stack and clears the status; no
// clearing pass is needed since only entries below the fill count are read.
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  itp_in_if.sink   in_i,
  itp_out_if.source out_o
);
  import itp_pkg::*;

  itp_cmd_t    cmd;
  itp_status_t status;

  itp_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  itp_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .character_i    (in_i.character),
    .finish_i       (in_i.finish),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .symbol_o       (out_o.symbol),
    .symbol_valid_o (out_o.symbol_valid),
    .last_o         (out_o.last),
    .out_status_o   (out_o.status)
  );

endmodule
